// ----- rtl/keyed_hex_text_encoder_macros.svh -----
// assertion helpers shared by the encoder modules
`ifndef KEYED_HEX_TEXT_ENCODER_MACROS_SVH
`define KEYED_HEX_TEXT_ENCODER_MACROS_SVH

// same-cycle implication, held off during reset
`define KHTE_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("khte check failed");

// next-cycle implication, held off during reset
`define KHTE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("khte check failed");

`endif

// ----- rtl/khte_pkg.sv -----
`timescale 1ns / 1ps

package khte_pkg;

    localparam int unsigned COL_W  = 8;
    localparam int unsigned VAL_W  = 16;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 3;
    localparam int unsigned KEY_W  = 15;

    localparam logic [WORD_W-1:0] NEWLINE_WORD = 32'h0A00_0000;
    localparam logic [CNT_W-1:0]  CNT_GROUP    = 3'd4;
    localparam logic [CNT_W-1:0]  CNT_NEWLINE  = 3'd1;

    typedef enum logic [1:0] {
        OPC_START  = 2'd0,
        OPC_DATA   = 2'd1,
        OPC_FINISH = 2'd2,
        OPC_RSVD   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        FMT_PASS    = 2'd0,
        FMT_ADD     = 2'd1,
        FMT_XOR     = 2'd2,
        FMT_NEWLINE = 2'd3
    } fmt_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DATA,
        S_SIG,
        S_NL
    } seq_state_t;

    typedef struct packed {
        logic             valid;
        fmt_op_t          op;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic             last;
    } fmt_req_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] base;
        base = (nib < 4'd10) ? 8'h30 : 8'h57;
        hex_char = base + {4'h0, nib};
    endfunction

    function automatic logic [WORD_W-1:0] hex_word(input logic [VAL_W-1:0] v);
        hex_word = {hex_char(v[15:12]), hex_char(v[11:8]), hex_char(v[7:4]), hex_char(v[3:0])};
    endfunction

endpackage

// ----- rtl/khte_fmt.sv -----
`timescale 1ns / 1ps

module khte_fmt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  khte_pkg::fmt_req_t           req,
    output logic                         take,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [khte_pkg::WORD_W-1:0]  text_word,
    output logic [khte_pkg::CNT_W-1:0]   char_count,
    output logic                         last_of_run
);

`include "keyed_hex_text_encoder_macros.svh"

    logic                        valid_reg, valid_next;
    logic [khte_pkg::WORD_W-1:0] word_reg, word_next;
    logic [khte_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        last_reg, last_next;
    logic [khte_pkg::VAL_W-1:0]  value;

    // shared add / xor unit feeding the hex converter
    always_comb
    begin
        case (req.op)
            khte_pkg::FMT_ADD:  value = req.a + req.b;
            khte_pkg::FMT_XOR:  value = req.a ^ req.b;
            khte_pkg::FMT_PASS: value = req.a;
            default:            value = req.a;
        endcase
    end

    assign take = req.valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        count_next = count_reg;
        last_next  = last_reg;
        if (take)
        begin
            valid_next = 1'b1;
            last_next  = req.last;
            if (req.op == khte_pkg::FMT_NEWLINE)
            begin
                word_next  = khte_pkg::NEWLINE_WORD;
                count_next = khte_pkg::CNT_NEWLINE;
            end
            else
            begin
                word_next  = khte_pkg::hex_word(value);
                count_next = khte_pkg::CNT_GROUP;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        count_reg <= count_next;
        last_reg  <= last_next;
    end

    assign out_valid   = valid_reg;
    assign text_word   = word_reg;
    assign char_count  = count_reg;
    assign last_of_run = last_reg;

    `KHTE_ASSERT_NOW(a_count_legal, clk, rst_n, valid_reg,
        (count_reg == khte_pkg::CNT_GROUP) || (count_reg == khte_pkg::CNT_NEWLINE))
    `KHTE_ASSERT_NOW(a_newline_word, clk, rst_n, valid_reg && (count_reg == khte_pkg::CNT_NEWLINE),
        word_reg == khte_pkg::NEWLINE_WORD)
    `KHTE_ASSERT_NOW(a_newline_last, clk, rst_n, valid_reg && (count_reg == khte_pkg::CNT_NEWLINE),
        last_reg)

endmodule

// ----- rtl/khte_seq.sv -----
`timescale 1ns / 1ps

module khte_seq
#(
    parameter int unsigned LINE_WIDTH = 80
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [khte_pkg::KEY_W-1:0]  cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  opcode,
    input  logic [63:0]                 file_size,
    input  logic [7:0]                  data_byte,
    output khte_pkg::fmt_req_t          req,
    input  logic                        take
);

`include "keyed_hex_text_encoder_macros.svh"

    localparam int unsigned GW = $clog2(LINE_WIDTH / 4 + 1);
    localparam logic [khte_pkg::COL_W-1:0] LW       = khte_pkg::COL_W'(LINE_WIDTH);
    localparam logic [khte_pkg::COL_W-1:0] LW_START = khte_pkg::COL_W'(LINE_WIDTH - 16);

    khte_pkg::seq_state_t           state_reg, state_next;
    logic [khte_pkg::COL_W-1:0]     cols_reg, cols_next;
    logic [khte_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [63:0]                    size_reg, size_next;
    logic [7:0]                     byte_reg, byte_next;
    logic                           nl_reg, nl_next;
    logic [1:0]                     part_reg, part_next;
    logic [GW-1:0]                  grp_reg, grp_next;
    logic [GW-1:0]                  total_reg, total_next;
    logic [GW-1:0]                  grp_inc;
    logic                           accept;

    assign in_ready = (state_reg == khte_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign grp_inc  = grp_reg + GW'(1);
    assign key_next = cfg_we ? cfg_wdata : key_reg;

    always_comb
    begin
        state_next = state_reg;
        cols_next  = cols_reg;
        size_next  = size_reg;
        byte_next  = byte_reg;
        nl_next    = nl_reg;
        part_next  = part_reg;
        grp_next   = grp_reg;
        total_next = total_reg;
        req.valid  = 1'b0;
        req.op     = khte_pkg::FMT_PASS;
        req.a      = size_reg[63:48];
        req.b      = '0;
        req.last   = 1'b0;
        case (state_reg)
            khte_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (khte_pkg::opcode_t'(opcode))
                        khte_pkg::OPC_START:
                        begin
                            size_next  = file_size;
                            part_next  = 2'd0;
                            cols_next  = LW_START;
                            state_next = khte_pkg::S_START;
                        end
                        khte_pkg::OPC_DATA:
                        begin
                            byte_next  = data_byte;
                            nl_next    = (cols_reg <= 8'd4);
                            cols_next  = (cols_reg <= 8'd4) ? LW : cols_reg - 8'd4;
                            state_next = khte_pkg::S_DATA;
                        end
                        khte_pkg::OPC_FINISH:
                        begin
                            total_next = GW'(cols_reg >> 2);
                            grp_next   = '0;
                            cols_next  = LW;
                            state_next = (cols_reg < 8'd4) ? khte_pkg::S_NL : khte_pkg::S_SIG;
                        end
                        default:
                        begin
                            state_next = khte_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            khte_pkg::S_START:
            begin
                req.valid = 1'b1;
                req.op    = khte_pkg::FMT_PASS;
                req.a     = size_reg[63:48];
                req.last  = (part_reg == 2'd3);
                if (take)
                begin
                    size_next = {size_reg[47:0], 16'h0000};
                    part_next = part_reg + 2'd1;
                    if (part_reg == 2'd3)
                    begin
                        state_next = khte_pkg::S_IDLE;
                    end
                end
            end
            khte_pkg::S_DATA:
            begin
                req.valid = 1'b1;
                req.op    = khte_pkg::FMT_ADD;
                req.a     = {4'h0, byte_reg, 4'h0};
                req.b     = {1'b0, key_reg};
                req.last  = !nl_reg;
                if (take)
                begin
                    state_next = nl_reg ? khte_pkg::S_NL : khte_pkg::S_IDLE;
                end
            end
            khte_pkg::S_SIG:
            begin
                req.valid = 1'b1;
                req.op    = khte_pkg::FMT_XOR;
                req.a     = khte_pkg::VAL_W'({grp_reg, 4'h0});
                req.b     = {5'b00000, key_reg[14:4]};
                if (take)
                begin
                    grp_next = grp_inc;
                    if (grp_inc == total_reg)
                    begin
                        state_next = khte_pkg::S_NL;
                    end
                end
            end
            khte_pkg::S_NL:
            begin
                req.valid = 1'b1;
                req.op    = khte_pkg::FMT_NEWLINE;
                req.last  = 1'b1;
                if (take)
                begin
                    state_next = khte_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = khte_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= khte_pkg::S_IDLE;
            cols_reg  <= LW;
            key_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cols_reg  <= cols_next;
            key_reg   <= key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg  <= size_next;
        byte_reg  <= byte_next;
        nl_reg    <= nl_next;
        part_reg  <= part_next;
        grp_reg   <= grp_next;
        total_reg <= total_next;
    end

    `KHTE_ASSERT_NOW(a_cols_bound, clk, rst_n, 1'b1, cols_reg <= LW)
    `KHTE_ASSERT_NOW(a_sig_in_range, clk, rst_n, state_reg == khte_pkg::S_SIG,
        grp_reg < total_reg)
    `KHTE_ASSERT_NEXT(a_start_ends, clk, rst_n,
        (state_reg == khte_pkg::S_START) && take && (part_reg == 2'd3),
        state_reg == khte_pkg::S_IDLE)

endmodule

// ----- rtl/keyed_hex_text_encoder.sv -----
`timescale 1ns / 1ps
// channel | direction | payload                             | handshake
// input   | in        | opcode, file_size, data_byte        | in_valid / in_ready
// output  | out       | text_word, char_count, last_of_run  | out_valid / out_ready
// config  | in        | cfg_wdata (key offset)              | cfg_we
// items are taken only when idle; each result word goes through the shared formatter
// data byte: 1 word, 2 on a line wrap; start: 4 words; finish: columns_left/4 + newline
// a stalled output holds the formatter and the sequencer in place
// rst_n clears state, key offset and output valid; columns_left resets to LINE_WIDTH

module keyed_hex_text_encoder
#(
    parameter int unsigned LINE_WIDTH = 80
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [khte_pkg::KEY_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   opcode,
    input  logic [63:0]                  file_size,
    input  logic [7:0]                   data_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [khte_pkg::WORD_W-1:0]  text_word,
    output logic [khte_pkg::CNT_W-1:0]   char_count,
    output logic                         last_of_run
);

    khte_pkg::fmt_req_t req;
    logic               take;

    khte_seq
    #(
        .LINE_WIDTH (LINE_WIDTH)
    )
    u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .file_size (file_size),
        .data_byte (data_byte),
        .req       (req),
        .take      (take)
    );

    khte_fmt u_fmt
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .take        (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .text_word   (text_word),
        .char_count  (char_count),
        .last_of_run (last_of_run)
    );

endmodule
